FILE: hw/rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg - shared types and constants for the C token scanner
// Token kind codes, source byte values and the operator lookup table.
// ----------------------------------------------------------------------------
package cts_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [5:0]  kind_t;
  typedef logic [15:0] tok_len_t;

  // Token kinds, densely numbered
  localparam kind_t K_SPACE     = 6'd0;
  localparam kind_t K_LINE      = 6'd1;
  localparam kind_t K_IDENT     = 6'd2;
  localparam kind_t K_NUMBER    = 6'd3;
  localparam kind_t K_LPAREN    = 6'd4;
  localparam kind_t K_RPAREN    = 6'd5;
  localparam kind_t K_LBRACE    = 6'd6;
  localparam kind_t K_RBRACE    = 6'd7;
  localparam kind_t K_LBRACK    = 6'd8;
  localparam kind_t K_RBRACK    = 6'd9;
  localparam kind_t K_SEMI      = 6'd10;
  localparam kind_t K_COMMA     = 6'd11;
  localparam kind_t K_DOT       = 6'd12;
  localparam kind_t K_ASSIGN    = 6'd13;
  localparam kind_t K_EQ        = 6'd14;
  localparam kind_t K_GT        = 6'd15;
  localparam kind_t K_GE        = 6'd16;
  localparam kind_t K_SHR       = 6'd17;
  localparam kind_t K_SHR_EQ    = 6'd18;
  localparam kind_t K_LT        = 6'd19;
  localparam kind_t K_LE        = 6'd20;
  localparam kind_t K_SHL       = 6'd21;
  localparam kind_t K_SHL_EQ    = 6'd22;
  localparam kind_t K_NOT       = 6'd23;
  localparam kind_t K_NE        = 6'd24;
  localparam kind_t K_TILDE     = 6'd25;
  localparam kind_t K_QUEST     = 6'd26;
  localparam kind_t K_COLON     = 6'd27;
  localparam kind_t K_HASH      = 6'd28;
  localparam kind_t K_AND       = 6'd29;
  localparam kind_t K_LAND      = 6'd30;
  localparam kind_t K_AND_EQ    = 6'd31;
  localparam kind_t K_OR        = 6'd32;
  localparam kind_t K_LOR       = 6'd33;
  localparam kind_t K_OR_EQ     = 6'd34;
  localparam kind_t K_PLUS      = 6'd35;
  localparam kind_t K_INC       = 6'd36;
  localparam kind_t K_PLUS_EQ   = 6'd37;
  localparam kind_t K_MINUS     = 6'd38;
  localparam kind_t K_DEC       = 6'd39;
  localparam kind_t K_MINUS_EQ  = 6'd40;
  localparam kind_t K_STAR      = 6'd41;
  localparam kind_t K_STAR_EQ   = 6'd42;
  localparam kind_t K_PCT       = 6'd43;
  localparam kind_t K_PCT_EQ    = 6'd44;
  localparam kind_t K_XOR       = 6'd45;
  localparam kind_t K_XOR_EQ    = 6'd46;
  localparam kind_t K_SLASH     = 6'd47;
  localparam kind_t K_SLASH_EQ  = 6'd48;
  localparam kind_t K_END       = 6'd49;
  localparam kind_t K_UNREC     = 6'd50;

  // Special byte values
  localparam char_t CH_TAB = 8'h09;
  localparam char_t CH_LF  = 8'h0A;
  localparam char_t CH_CR  = 8'h0D;
  localparam char_t CH_EOT = 8'hFF;

  // One result item
  typedef struct packed {
    kind_t    kind;
    tok_len_t len;
    logic     last;
  } tok_t;

  // Follow-up behavior of a pending operator byte
  typedef struct packed {
    logic  is_op;
    kind_t base;
    logic  has_dbl;
    kind_t dbl;
    logic  has_eq;
    kind_t eq;
  } op_info_t;

  function automatic logic is_digit(char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(char_t c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) ||
           (c == "$") || (c == "_");
  endfunction

  function automatic logic is_hex(char_t c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  // Look up single, doubled and '='-suffixed kinds of an operator byte
  function automatic op_info_t op_lookup(char_t p);
    op_info_t r;
    r = '{is_op: 1'b1, base: K_UNREC, has_dbl: 1'b0, dbl: K_UNREC,
          has_eq: 1'b1, eq: K_UNREC};
    case (p)
      "=": begin r.base = K_ASSIGN; r.has_dbl = 1'b1; r.dbl = K_EQ; r.has_eq = 1'b0; end
      "!": begin r.base = K_NOT;   r.eq = K_NE; end
      "&": begin r.base = K_AND;   r.has_dbl = 1'b1; r.dbl = K_LAND; r.eq = K_AND_EQ; end
      "|": begin r.base = K_OR;    r.has_dbl = 1'b1; r.dbl = K_LOR;  r.eq = K_OR_EQ; end
      "+": begin r.base = K_PLUS;  r.has_dbl = 1'b1; r.dbl = K_INC;  r.eq = K_PLUS_EQ; end
      "-": begin r.base = K_MINUS; r.has_dbl = 1'b1; r.dbl = K_DEC;  r.eq = K_MINUS_EQ; end
      "*": begin r.base = K_STAR;  r.eq = K_STAR_EQ; end
      "%": begin r.base = K_PCT;   r.eq = K_PCT_EQ; end
      "^": begin r.base = K_XOR;   r.eq = K_XOR_EQ; end
      "/": begin r.base = K_SLASH; r.eq = K_SLASH_EQ; end
      default: r.is_op = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/c_token_scanner_core.sv
// ----------------------------------------------------------------------------
// c_token_scanner_core - streaming C-style lexer
// Scans one source byte per transfer and emits token kind and length for
// every token closed by that byte; a byte may close one token and form another.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Ports                                   Handshake
//  -------  ---------  --------------------------------------  --------------
//  in       input      in_char_in                              in_valid/in_stall
//  out      output     out_token_kind, out_token_length,       out_valid/out_stall
//                      out_last
//
//  One byte per cycle is taken while in_stall is low; the scan state and up to two tokens are
//  computed in the same cycle and pushed into a four-entry result queue.
//  The queue drains one token per cycle while out_stall is low; in_stall rises only while fewer
//  than two queue slots are free, so a byte never has to wait on a stall
//  when the sink keeps up with the token rate.
//  rst_n (synchronous) returns the scanner to idle and empties the queue.
//
module c_token_scanner_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cts_pkg::char_t   in_char_in,
  output logic             out_valid,
  input  logic             out_stall,
  output cts_pkg::kind_t   out_token_kind,
  output cts_pkg::tok_len_t out_token_length,
  output logic             out_last
);
  import cts_pkg::*;

  // Run counter width: the token length saturates at 16 bits at most
  localparam int LW     = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    M_IDLE, M_SPACE, M_CR, M_IDENT, M_ZERO, M_NUM, M_HEX, M_OP1,
    M_GT2, M_LT2, M_LCOM, M_BCOM, M_BSTAR
  } mode_t;

  mode_t           mode_r, mode_nxt;
  char_t           pend_r, pend_nxt;
  logic [LW-1:0]   run_r, run_nxt, run_bump;

  tok_t            q_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [QCW-1:0]  cnt_r, cnt_nxt;

  logic            accept, pop;
  char_t           c;

  // Fresh-start decode of the current byte
  mode_t           s_mode;
  logic            s_emit, s_load, s_pend;
  kind_t           s_kind;

  // Step outcome
  logic            e0, take_start;
  kind_t           k0;
  tok_len_t        l0, run_len;
  op_info_t        op;
  tok_t            r0, r1;
  logic [1:0]      n_push;

  assign c        = in_char_in;
  assign in_stall = (cnt_r > QCW'(QDEPTH - 2));
  assign accept   = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && !out_stall;
  assign run_bump = (run_r == '1) ? run_r : run_r + LW'(1);
  assign run_len  = 16'(run_r);
  assign op       = op_lookup(pend_r);

  // Decode the byte as the first byte of a new token
  always_comb begin
    s_mode = M_IDLE;
    s_emit = 1'b0;
    s_load = 1'b0;
    s_pend = 1'b0;
    s_kind = K_UNREC;
    if (c == " " || c == CH_TAB) begin
      s_mode = M_SPACE; s_load = 1'b1;
    end else if (is_alpha(c)) begin
      s_mode = M_IDENT; s_load = 1'b1;
    end else if (c == "0") begin
      s_mode = M_ZERO; s_load = 1'b1;
    end else if (is_digit(c)) begin
      s_mode = M_NUM; s_load = 1'b1;
    end else begin
      case (c)
        CH_LF: begin s_emit = 1'b1; s_kind = K_LINE; end
        CH_CR: s_mode = M_CR;
        "(": begin s_emit = 1'b1; s_kind = K_LPAREN; end
        ")": begin s_emit = 1'b1; s_kind = K_RPAREN; end
        "{": begin s_emit = 1'b1; s_kind = K_LBRACE; end
        "}": begin s_emit = 1'b1; s_kind = K_RBRACE; end
        "[": begin s_emit = 1'b1; s_kind = K_LBRACK; end
        "]": begin s_emit = 1'b1; s_kind = K_RBRACK; end
        ";": begin s_emit = 1'b1; s_kind = K_SEMI; end
        ",": begin s_emit = 1'b1; s_kind = K_COMMA; end
        ".": begin s_emit = 1'b1; s_kind = K_DOT; end
        "~": begin s_emit = 1'b1; s_kind = K_TILDE; end
        "?": begin s_emit = 1'b1; s_kind = K_QUEST; end
        ":": begin s_emit = 1'b1; s_kind = K_COLON; end
        "#": begin s_emit = 1'b1; s_kind = K_HASH; end
        "=", ">", "<", "!", "&", "|", "+", "-", "*", "%", "^", "/": begin
          s_mode = M_OP1; s_pend = 1'b1;
        end
        CH_EOT: begin s_emit = 1'b1; s_kind = K_END; end
        default: begin s_emit = 1'b1; s_kind = K_UNREC; end
      endcase
    end
  end

  // Advance the scan mode and close tokens
  always_comb begin
    e0         = 1'b0;
    k0         = K_UNREC;
    l0         = 16'd1;
    take_start = 1'b0;
    mode_nxt   = mode_r;
    run_nxt    = run_r;
    pend_nxt   = pend_r;
    unique case (mode_r)
      M_SPACE: begin
        if (c == " " || c == CH_TAB) run_nxt = run_bump;
        else begin e0 = 1'b1; k0 = K_SPACE; l0 = run_len; take_start = 1'b1; end
      end
      M_CR: begin
        e0 = 1'b1; k0 = K_LINE;
        if (c == CH_LF) begin mode_nxt = M_IDLE; l0 = 16'd2; end
        else take_start = 1'b1;
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) run_nxt = run_bump;
        else begin e0 = 1'b1; k0 = K_IDENT; l0 = run_len; take_start = 1'b1; end
      end
      M_ZERO: begin
        if (c == "x" || c == "X") begin
          mode_nxt = M_HEX; run_nxt = LW'(2);
        end else if (is_digit(c)) begin
          mode_nxt = M_NUM; run_nxt = LW'(2);
        end else begin
          e0 = 1'b1; k0 = K_NUMBER; take_start = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(c)) run_nxt = run_bump;
        else begin e0 = 1'b1; k0 = K_NUMBER; l0 = run_len; take_start = 1'b1; end
      end
      M_HEX: begin
        if (is_hex(c)) run_nxt = run_bump;
        else begin e0 = 1'b1; k0 = K_NUMBER; l0 = run_len; take_start = 1'b1; end
      end
      M_OP1: begin
        if (pend_r == ">") begin
          if (c == "=") begin
            mode_nxt = M_IDLE; e0 = 1'b1; k0 = K_GE; l0 = 16'd2;
          end else if (c == ">") mode_nxt = M_GT2;
          else begin e0 = 1'b1; k0 = K_GT; take_start = 1'b1; end
        end else if (pend_r == "<") begin
          if (c == "=") begin
            mode_nxt = M_IDLE; e0 = 1'b1; k0 = K_LE; l0 = 16'd2;
          end else if (c == "<") mode_nxt = M_LT2;
          else begin e0 = 1'b1; k0 = K_LT; take_start = 1'b1; end
        end else if (pend_r == "/" && c == "/") begin
          mode_nxt = M_LCOM;
        end else if (pend_r == "/" && c == "*") begin
          mode_nxt = M_BCOM;
        end else if (!op.is_op) begin
          take_start = 1'b1;
        end else if (op.has_dbl && c == pend_r) begin
          mode_nxt = M_IDLE; e0 = 1'b1; k0 = op.dbl; l0 = 16'd2;
        end else if (op.has_eq && c == "=") begin
          mode_nxt = M_IDLE; e0 = 1'b1; k0 = op.eq; l0 = 16'd2;
        end else begin
          e0 = 1'b1; k0 = op.base; take_start = 1'b1;
        end
      end
      M_GT2: begin
        e0 = 1'b1;
        if (c == "=") begin mode_nxt = M_IDLE; k0 = K_SHR_EQ; l0 = 16'd3; end
        else begin k0 = K_SHR; l0 = 16'd2; take_start = 1'b1; end
      end
      M_LT2: begin
        e0 = 1'b1;
        if (c == "=") begin mode_nxt = M_IDLE; k0 = K_SHL_EQ; l0 = 16'd3; end
        else begin k0 = K_SHL; l0 = 16'd2; take_start = 1'b1; end
      end
      M_LCOM: begin
        if (c == CH_CR || c == CH_LF || c == CH_EOT) take_start = 1'b1;
      end
      M_BCOM: begin
        if (c == "*") mode_nxt = M_BSTAR;
        else if (c == CH_EOT) take_start = 1'b1;
      end
      M_BSTAR: begin
        if (c == "/") mode_nxt = M_IDLE;
        else if (c == CH_EOT) take_start = 1'b1;
        else if (c != "*") mode_nxt = M_BCOM;
      end
      default: take_start = 1'b1;
    endcase
    // Rescan the closing byte from idle
    if (take_start) begin
      mode_nxt = s_mode;
      if (s_load) run_nxt = LW'(1);
      if (s_pend) pend_nxt = c;
    end
  end

  // Order the results of this byte and mark the final one
  always_comb begin
    n_push = 2'(e0) + 2'(take_start && s_emit);
    if (e0) begin
      r0 = '{kind: k0, len: l0, last: (n_push == 2'd1)};
    end else begin
      r0 = '{kind: s_kind, len: 16'd1, last: 1'b1};
    end
    r1 = '{kind: s_kind, len: 16'd1, last: 1'b1};
  end

  assign wr_ptr_p1 = wr_ptr_r + QAW'(1);
  assign cnt_nxt   = cnt_r + (accept ? QCW'(n_push) : '0) - QCW'(pop);

  // Hold scan state and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pend_r   <= '0;
      run_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        pend_r   <= pend_nxt;
        run_r    <= run_nxt;
        wr_ptr_r <= wr_ptr_r + QAW'(n_push);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Write up to two tokens per transfer into the result queue
  always_ff @(posedge clk) begin
    if (accept && n_push != 2'd0) q_r[wr_ptr_r] <= r0;
    if (accept && n_push == 2'd2) q_r[wr_ptr_p1] <= r1;
  end

  assign out_token_kind   = q_r[rd_ptr_r].kind;
  assign out_token_length = q_r[rd_ptr_r].len;
  assign out_last         = q_r[rd_ptr_r].last;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - C token scanner stream check
// Feeds source bytes to the scanner and compares every emitted token against
// an in-bench scan model: directed text for corner cases, a long blank run,
// then random C-like text under mixed source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  import cts_pkg::*;

  localparam int       LEN_BITS   = 16;
  localparam tok_len_t LEN_CAP    = tok_len_t'((64'd1 << LEN_BITS) - 1);
  localparam int       BLANK_RUN  = 40;
  localparam int       IDLE_LIMIT = 2000;
  localparam int       CHUNKS     = 10;
  localparam int       CHUNK_BYTES = 80;

  // Scan modes of the model
  typedef enum logic [3:0] {
    S_IDLE, S_BLANK, S_CR, S_WORD, S_ZERO, S_DEC, S_HEX, S_OP, S_GT2, S_LT2,
    S_LINECMT, S_BLKCMT, S_BLKSTAR
  } scan_state_t;

  // Token scan model and queue of expected tokens
  class token_scoreboard;
    scan_state_t state;
    char_t       op_byte;
    tok_len_t    run_len;
    tok_t        expected_toks[$];
    int          mismatches;
    int          checked;

    function new();
      state       = S_IDLE;
      op_byte     = '0;
      run_len     = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function bit blank(char_t c);
      return (c == " ") || (c == CH_TAB);
    endfunction

    function bit decimal(char_t c);
      return (c >= "0") && (c <= "9");
    endfunction

    function bit word_head(char_t c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function bit hex_char(char_t c);
      return decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function void add(kind_t k, tok_len_t l);
      tok_t t;
      t.kind = k;
      t.len  = l;
      t.last = 1'b0;
      expected_toks.push_back(t);
    endfunction

    function void grow();
      if (run_len != LEN_CAP) run_len++;
    endfunction

    // Scan c as the first byte of a fresh token
    function void begin_token(char_t c);
      state = S_IDLE;
      if (blank(c)) begin
        state   = S_BLANK;
        run_len = 1;
      end else if (word_head(c)) begin
        state   = S_WORD;
        run_len = 1;
      end else if (c == "0") begin
        state   = S_ZERO;
        run_len = 1;
      end else if (decimal(c)) begin
        state   = S_DEC;
        run_len = 1;
      end else begin
        case (c)
          CH_LF: add(K_LINE, 1);
          CH_CR: state = S_CR;
          "(": add(K_LPAREN, 1);
          ")": add(K_RPAREN, 1);
          "{": add(K_LBRACE, 1);
          "}": add(K_RBRACE, 1);
          "[": add(K_LBRACK, 1);
          "]": add(K_RBRACK, 1);
          ";": add(K_SEMI, 1);
          ",": add(K_COMMA, 1);
          ".": add(K_DOT, 1);
          "~": add(K_TILDE, 1);
          "?": add(K_QUEST, 1);
          ":": add(K_COLON, 1);
          "#": add(K_HASH, 1);
          "=", ">", "<", "!", "&", "|", "+", "-", "*", "%", "^", "/": begin
            state   = S_OP;
            op_byte = c;
          end
          CH_EOT: add(K_END, 1);
          default: add(K_UNREC, 1);
        endcase
      end
    endfunction

    // Resolve a held operator byte p against the next byte c
    function void after_op(char_t p, char_t c);
      kind_t single, twin, with_eq;
      bit    twin_ok, eq_ok;
      single  = K_UNREC;
      twin    = K_UNREC;
      with_eq = K_UNREC;
      twin_ok = 1'b0;
      eq_ok   = 1'b1;
      case (p)
        "=": begin
          single = K_ASSIGN; twin_ok = 1'b1; twin = K_EQ; eq_ok = 1'b0;
        end
        ">": begin
          if (c == "=") begin
            state = S_IDLE;
            add(K_GE, 2);
          end else if (c == ">") begin
            state = S_GT2;
          end else begin
            add(K_GT, 1);
            begin_token(c);
          end
          return;
        end
        "<": begin
          if (c == "=") begin
            state = S_IDLE;
            add(K_LE, 2);
          end else if (c == "<") begin
            state = S_LT2;
          end else begin
            add(K_LT, 1);
            begin_token(c);
          end
          return;
        end
        "!": begin single = K_NOT; with_eq = K_NE; end
        "&": begin single = K_AND; twin_ok = 1'b1; twin = K_LAND; with_eq = K_AND_EQ; end
        "|": begin single = K_OR; twin_ok = 1'b1; twin = K_LOR; with_eq = K_OR_EQ; end
        "+": begin single = K_PLUS; twin_ok = 1'b1; twin = K_INC; with_eq = K_PLUS_EQ; end
        "-": begin single = K_MINUS; twin_ok = 1'b1; twin = K_DEC; with_eq = K_MINUS_EQ; end
        "*": begin single = K_STAR; with_eq = K_STAR_EQ; end
        "%": begin single = K_PCT; with_eq = K_PCT_EQ; end
        "^": begin single = K_XOR; with_eq = K_XOR_EQ; end
        "/": begin
          if (c == "/") begin
            state = S_LINECMT;
            return;
          end
          if (c == "*") begin
            state = S_BLKCMT;
            return;
          end
          single = K_SLASH; with_eq = K_SLASH_EQ;
        end
        default: begin
          begin_token(c);
          return;
        end
      endcase
      if (twin_ok && c == p) begin
        state = S_IDLE;
        add(twin, 2);
      end else if (eq_ok && c == "=") begin
        state = S_IDLE;
        add(with_eq, 2);
      end else begin
        add(single, 1);
        begin_token(c);
      end
    endfunction

    // Advance the scan by one accepted byte and queue the tokens it closes
    function void note_byte(char_t c);
      int before_n;
      before_n = expected_toks.size();
      case (state)
        S_BLANK: begin
          if (blank(c)) grow();
          else begin
            add(K_SPACE, run_len);
            begin_token(c);
          end
        end
        S_CR: begin
          if (c == CH_LF) begin
            state = S_IDLE;
            add(K_LINE, 2);
          end else begin
            add(K_LINE, 1);
            begin_token(c);
          end
        end
        S_WORD: begin
          if (word_head(c) || decimal(c)) grow();
          else begin
            add(K_IDENT, run_len);
            begin_token(c);
          end
        end
        S_ZERO: begin
          if (c == "x" || c == "X") begin
            state   = S_HEX;
            run_len = 2;
          end else if (decimal(c)) begin
            state   = S_DEC;
            run_len = 2;
          end else begin
            add(K_NUMBER, 1);
            begin_token(c);
          end
        end
        S_DEC: begin
          if (decimal(c)) grow();
          else begin
            add(K_NUMBER, run_len);
            begin_token(c);
          end
        end
        S_HEX: begin
          if (hex_char(c)) grow();
          else begin
            add(K_NUMBER, run_len);
            begin_token(c);
          end
        end
        S_OP: after_op(op_byte, c);
        S_GT2: begin
          if (c == "=") begin
            state = S_IDLE;
            add(K_SHR_EQ, 3);
          end else begin
            add(K_SHR, 2);
            begin_token(c);
          end
        end
        S_LT2: begin
          if (c == "=") begin
            state = S_IDLE;
            add(K_SHL_EQ, 3);
          end else begin
            add(K_SHL, 2);
            begin_token(c);
          end
        end
        S_LINECMT: begin
          if (c == CH_CR || c == CH_LF || c == CH_EOT) begin_token(c);
        end
        S_BLKCMT: begin
          if (c == "*") state = S_BLKSTAR;
          else if (c == CH_EOT) begin_token(c);
        end
        S_BLKSTAR: begin
          if (c == "/") state = S_IDLE;
          else if (c == CH_EOT) begin_token(c);
          else if (c != "*") state = S_BLKCMT;
        end
        default: begin_token(c);
      endcase
      // Flag the final token of this byte
      if (expected_toks.size() > before_n)
        expected_toks[expected_toks.size() - 1].last = 1'b1;
    endfunction

    // Compare one emitted token with the oldest expected one
    function void check_token(kind_t k, tok_len_t l, logic lst);
      tok_t want;
      if (expected_toks.size() == 0) begin
        $display("%0t: token with none expected: expected nothing, got kind %0d len %0d last %0b",
                 $time, k, l, lst);
        mismatches++;
        return;
      end
      want = expected_toks.pop_front();
      checked++;
      if (want.kind != k) begin
        $display("%0t: token %0d kind: expected %0d, got %0d", $time, checked, want.kind, k);
        mismatches++;
      end
      if (want.len != l) begin
        $display("%0t: token %0d length: expected %0d, got %0d", $time, checked, want.len, l);
        mismatches++;
      end
      if (want.last != lst) begin
        $display("%0t: token %0d last: expected %0b, got %0b", $time, checked, want.last, lst);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_toks.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  char_t    in_char_in;
  logic     out_valid;
  logic     out_stall;
  kind_t    out_token_kind;
  tok_len_t out_token_length;
  logic     out_last;

  token_scoreboard sb;
  bit    sender_idles;
  bit    sink_idles;
  int    sent_count;
  int    idle_cycles;
  char_t snippet[$];

  string op_spellings [0:44] = '{
    "=", "==", ">", ">=", ">>", ">>=", "<", "<=", "<<", "<<=",
    "!", "!=", "~", "?", ":", "#", "&", "&&", "&=", "|", "||", "|=",
    "+", "++", "+=", "-", "--", "-=", "*", "*=", "%", "%=", "^", "^=",
    "/", "/=", "(", ")", "{", "}", "[", "]", ";", ",", "."
  };

  c_token_scanner_core #(
    .LENGTH_BITS(LEN_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_token_length(out_token_length),
    .out_last        (out_last)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note every transfer on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_char_in);
      if (out_valid && !out_stall)
        sb.check_token(out_token_kind, out_token_length, out_last);
    end
  end

  // Watchdog: count cycles with no transfer on either channel and fail the run at IDLE_LIMIT
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d tokens still expected",
                 IDLE_LIMIT, sb.outstanding());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Token sink with random stalls
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = sink_idles ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Send one byte after an optional gap; return at its transfer edge
  task automatic send_char(input char_t c);
    int gap;
    gap = sender_idles ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic feed_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hold the source until every expected token has come out
  task automatic wait_for_tokens();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic char_t pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Build one random C-like fragment, mostly well formed
  task automatic compose_snippet();
    int    sel;
    string op;
    snippet.delete();
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1, 2, 3: begin
        snippet.push_back(pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$"));
        repeat ($urandom_range(0, 10))
          snippet.push_back(pick_from("abcxyzAQZ_$0123456789"));
      end
      4, 5: begin
        snippet.push_back(pick_from("123456789"));
        repeat ($urandom_range(0, 6)) snippet.push_back(pick_from("0123456789"));
      end
      6: begin
        snippet.push_back("0");
        snippet.push_back(pick_from("xX"));
        repeat ($urandom_range(0, 6)) snippet.push_back(pick_from("0123456789abcdefABCDEF"));
      end
      7: begin
        snippet.push_back("0");
        repeat ($urandom_range(0, 3)) snippet.push_back(pick_from("0123456789"));
      end
      8, 9: repeat ($urandom_range(1, 6)) snippet.push_back(pick_from(" \t"));
      10: begin
        case ($urandom_range(0, 2))
          0: snippet.push_back(CH_LF);
          1: snippet.push_back(CH_CR);
          default: begin
            snippet.push_back(CH_CR);
            snippet.push_back(CH_LF);
          end
        endcase
      end
      11, 12, 13, 14: begin
        op = op_spellings[$urandom_range(0, $size(op_spellings) - 1)];
        for (int i = 0; i < op.len(); i++) snippet.push_back(op[i]);
      end
      15: begin
        snippet.push_back("/");
        snippet.push_back("/");
        repeat ($urandom_range(0, 8)) snippet.push_back(pick_from("ab /*=\t9"));
        case ($urandom_range(0, 3))
          0: snippet.push_back(CH_LF);
          1: snippet.push_back(CH_CR);
          2: snippet.push_back(CH_EOT);
          default: ;
        endcase
      end
      16: begin
        snippet.push_back("/");
        snippet.push_back("*");
        repeat ($urandom_range(0, 10)) snippet.push_back(pick_from("ab **\n/x"));
        if ($urandom_range(0, 1)) snippet.push_back("*");
        snippet.push_back("*");
        snippet.push_back("/");
      end
      17: snippet.push_back(CH_EOT);
      default: snippet.push_back(char_t'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    int random_bytes;
    int chunk_bytes;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_in   = '0;
    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    sent_count   = 0;
    idle_cycles  = 0;
    random_bytes = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text: line ends, number forms, three-byte shifts, comments
    feed_string("a\r\n\r;0x 0X1fG 007 0a>>=<<=>>b<<\n//c\rq/*a**/>=");
    // End of text inside a block comment, then inside a line comment
    send_char("/");
    send_char("*");
    send_char(CH_EOT);
    feed_string("//z");
    send_char(CH_EOT);
    // Byte extremes
    send_char(8'h00);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(CH_EOT);

    // Long blank run of mixed tabs and spaces, no source gaps
    sender_idles = 1'b0;
    for (int i = 0; i < BLANK_RUN; i++) send_char((i % 3 == 0) ? CH_TAB : " ");
    send_char("a");
    wait_for_tokens();

    // Random text, cycling through gap and stall mixes
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      sender_idles = (chunk % 4 == 0) || (chunk % 4 == 1);
      sink_idles   = (chunk % 4 == 0) || (chunk % 4 == 2);
      chunk_bytes  = 0;
      while (chunk_bytes < CHUNK_BYTES) begin
        compose_snippet();
        foreach (snippet[i]) send_char(snippet[i]);
        chunk_bytes += snippet.size();
      end
      random_bytes += chunk_bytes;
      if (chunk == CHUNKS / 2) wait_for_tokens();
    end
    send_char(CH_EOT);

    // Drain and let any stray token show up
    wait_for_tokens();
    repeat (16) @(posedge clk);

    $display("Run covered %0d bytes (%0d random, %0d-byte blank run), %0d tokens",
             sent_count, random_bytes, BLANK_RUN, sb.checked);
    $display("Text mixed all operators, numbers, comments cut by end of text, gaps and stalls");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
